// ===== rtl/core/barometric_pressure_compensation_assert.svh =====
// Assertion macros shared by the pressure compensation checker
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define BPC_ASSERT_NOW(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/core/bpc_pkg.sv =====
// Shared constants for the pressure compensation block
package bpc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_AC123 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AC456 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B12   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MCMD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OSS   = 3'd4;

  localparam int DIV_W = 32;

  localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
  localparam logic signed [31:0] P_C1       = 32'sd3038;
  localparam logic signed [31:0] P_C2       = -32'sd7357;
  localparam logic signed [31:0] P_C3       = 32'sd3791;
  localparam logic [31:0]        B7_SCALE   = 32'd50000;
  localparam logic [31:0]        B4_BIAS    = 32'd32768;

endpackage

// ===== rtl/core/barometric_pressure_compensation.sv =====
// Top level: pipelined temperature and pressure compensation
//
// Input channel: raw_temp and raw_pressure with in_valid/in_stall; a request
// is taken when in_valid is high and in_stall is low.
// Output channel: temp_tenths, pressure_pa and div_fault with
// out_valid/out_stall; one result per request, in order.
// Configuration: cfg_we, cfg_index, cfg_data; write only while no request
// is in flight. Index 0..4 selects the calibration words and oversampling.
// Throughput: one request per cycle while the output is not stalled. The
// pipe holds two 32-stage quotient pipelines (temperature term and pressure
// term) plus twelve arithmetic stages, each with at most one multiply on
// any path and a short add chain.
// The whole pipe advances together; while out_valid is high and out_stall
// is high nothing moves and in_stall is raised, so no request is lost or
// repeated.
// Reset (rst, synchronous) clears all valid bits and the configuration to
// zero. A zero divisor gives div_fault = 1 with both results zero.
module barometric_pressure_compensation (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    raw_temp,
  input  logic [18:0]                    raw_pressure,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             temp_tenths,
  output logic signed [31:0]             pressure_pa,
  output logic                           div_fault,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    logic signed [31:0] x1;
    logic               fault;
    logic               flip;
    logic [18:0]        up;
  } pay_a_t;

  typedef struct packed {
    logic signed [31:0] t;
    logic               fault;
    logic               dbl;
  } pay_b_t;

  // configuration
  logic [47:0] cal_ac123, cal_ac456;
  logic [31:0] cal_b12, cal_mcmd;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac123 <= '0;
      cal_ac456 <= '0;
      cal_b12   <= '0;
      cal_mcmd  <= '0;
      oss       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::CFG_AC123: cal_ac123 <= cfg_data;
        bpc_pkg::CFG_AC456: cal_ac456 <= cfg_data;
        bpc_pkg::CFG_B12:   cal_b12   <= cfg_data[31:0];
        bpc_pkg::CFG_MCMD:  cal_mcmd  <= cfg_data[31:0];
        bpc_pkg::CFG_OSS:   oss       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [31:0] ac4, ac5, ac6;
  assign ac1 = 32'(signed'(cal_ac123[15:0]));
  assign ac2 = 32'(signed'(cal_ac123[31:16]));
  assign ac3 = 32'(signed'(cal_ac123[47:32]));
  assign ac4 = {16'b0, cal_ac456[15:0]};
  assign ac5 = {16'b0, cal_ac456[31:16]};
  assign ac6 = {16'b0, cal_ac456[47:32]};
  assign b1  = 32'(signed'(cal_b12[15:0]));
  assign b2  = 32'(signed'(cal_b12[31:16]));
  assign mc  = 32'(signed'(cal_mcmd[15:0]));
  assign md  = 32'(signed'(cal_mcmd[31:16]));

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: temperature product
  logic        v1;
  logic [31:0] prod1;
  logic [18:0] up1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= ({16'b0, raw_temp} - ac6) * ac5;
      up1   <= raw_pressure;
    end
  end

  // stage 2: divisor and operand magnitudes
  logic signed [31:0] x1_c, den_c, num_c;
  assign x1_c  = $signed(prod1) >>> 15;
  assign den_c = x1_c + md;
  assign num_c = mc <<< 11;

  logic        v2;
  logic [31:0] ma2, mb2;
  pay_a_t      pa2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ma2      <= num_c[31] ? 32'(-num_c) : num_c;
      mb2      <= den_c[31] ? 32'(-den_c) : den_c;
      pa2.x1   <= x1_c;
      pa2.fault <= (den_c == 32'sd0);
      pa2.flip <= num_c[31] ^ den_c[31];
      pa2.up   <= up1;
    end
  end

  logic        va;
  logic [31:0] qa;
  logic [$bits(pay_a_t)-1:0] pa_raw;
  pay_a_t      pa;
  bpc_div #(.W(bpc_pkg::DIV_W), .PW($bits(pay_a_t))) u_div_temp (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .dividend(ma2), .divisor(mb2),
    .in_pay(pa2), .out_valid(va), .quotient(qa), .out_pay(pa_raw)
  );
  assign pa = pay_a_t'(pa_raw);

  // stage 3: B5, temperature, B6
  logic signed [31:0] x2_c, b5_c;
  assign x2_c = pa.flip ? 32'(-$signed(qa)) : $signed(qa);
  assign b5_c = pa.x1 + x2_c;

  logic               v3, f3;
  logic signed [31:0] t3, b6_3;
  logic [18:0]        up3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      t3   <= (b5_c + 32'sd8) >>> 4;
      b6_3 <= b5_c - bpc_pkg::B6_OFFSET;
      f3   <= pa.fault;
      up3  <= pa.up;
    end
  end

  // stage 4: products of B6
  logic               v4, f4;
  logic signed [31:0] t4, sqp4, a2p4, a3p4;
  logic [18:0]        up4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqp4 <= b6_3 * b6_3;
      a2p4 <= ac2 * b6_3;
      a3p4 <= ac3 * b6_3;
      t4   <= t3;
      f4   <= f3;
      up4  <= up3;
    end
  end

  // stage 5: products of the square term
  logic signed [31:0] sq_c;
  assign sq_c = sqp4 >>> 12;

  logic               v5, f5;
  logic signed [31:0] t5, b2sq5, b1sq5, a2p5, a3p5;
  logic [18:0]        up5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b2sq5 <= b2 * sq_c;
      b1sq5 <= b1 * sq_c;
      a2p5  <= a2p4;
      a3p5  <= a3p4;
      t5    <= t4;
      f5    <= f4;
      up5   <= up4;
    end
  end

  // stage 6: X3 terms for B3 and B4
  logic               v6, f6;
  logic signed [31:0] t6, x3b3_6, x3b4_6;
  logic [18:0]        up6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x3b3_6 <= (b2sq5 >>> 11) + (a2p5 >>> 11);
      x3b4_6 <= ((a3p5 >>> 13) + (b1sq5 >>> 16) + 32'sd2) >>> 2;
      t6     <= t5;
      f6     <= f5;
      up6    <= up5;
    end
  end

  // stage 7: B3 (divide by four toward zero) and B4 product
  logic signed [31:0] b3v_c;
  assign b3v_c = (((ac1 <<< 2) + x3b3_6) <<< oss) + 32'sd2;

  logic               v7, f7;
  logic signed [31:0] t7, b3_7;
  logic [31:0]        b4p7;
  logic [18:0]        up7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b3_7 <= (b3v_c + (b3v_c[31] ? 32'sd3 : 32'sd0)) >>> 2;
      b4p7 <= ac4 * ($unsigned(x3b4_6) + bpc_pkg::B4_BIAS);
      t7   <= t6;
      f7   <= f6;
      up7  <= up6;
    end
  end

  // stage 8: B4 and pressure difference
  logic [31:0] b4_c;
  assign b4_c = {15'b0, b4p7[31:15]};

  logic               v8, f8;
  logic signed [31:0] t8;
  logic [31:0]        b4_8, dp8;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b4_8 <= b4_c;
      dp8  <= {13'b0, up7} - $unsigned(b3_7);
      f8   <= f7 || (b4_c == 32'd0);
      t8   <= t7;
    end
  end

  // stage 9: B7
  logic               v9, f9;
  logic signed [31:0] t9;
  logic [31:0]        b4_9, b7_9;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b7_9 <= dp8 * (bpc_pkg::B7_SCALE >> oss);
      b4_9 <= b4_8;
      f9   <= f8;
      t9   <= t8;
    end
  end

  pay_b_t pb_in;
  assign pb_in.t     = t9;
  assign pb_in.fault = f9;
  assign pb_in.dbl   = b7_9[31];

  logic        vb;
  logic [31:0] qb;
  logic [$bits(pay_b_t)-1:0] pb_raw;
  pay_b_t      pb;
  bpc_div #(.W(bpc_pkg::DIV_W), .PW($bits(pay_b_t))) u_div_press (
    .clk(clk), .rst(rst), .en(en), .in_valid(v9),
    .dividend(b7_9[31] ? b7_9 : {b7_9[30:0], 1'b0}), .divisor(b4_9),
    .in_pay(pb_in), .out_valid(vb), .quotient(qb), .out_pay(pb_raw)
  );
  assign pb = pay_b_t'(pb_raw);

  // stage 10: first correction products
  logic signed [31:0] p_c, s_c;
  assign p_c = pb.dbl ? $signed({qb[30:0], 1'b0}) : $signed(qb);
  assign s_c = p_c >>> 8;

  logic               v10, f10;
  logic signed [31:0] t10, p10, sqp10, m2p10;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqp10 <= s_c * s_c;
      m2p10 <= bpc_pkg::P_C2 * p_c;
      p10   <= p_c;
      t10   <= pb.t;
      f10   <= pb.fault;
    end
  end

  // stage 11: scaled square
  logic               v11, f11;
  logic signed [31:0] t11, p11, x1p11, m2p11;
  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1p11 <= sqp10 * bpc_pkg::P_C1;
      m2p11 <= m2p10;
      p11   <= p10;
      t11   <= t10;
      f11   <= f10;
    end
  end

  // stage 12: final sum, output register
  logic signed [31:0] pf_c;
  assign pf_c = p11 + (((x1p11 >>> 16) + (m2p11 >>> 16) + bpc_pkg::P_C3) >>> 4);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v11;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      temp_tenths <= f11 ? 32'sd0 : t11;
      pressure_pa <= f11 ? 32'sd0 : pf_c;
      div_fault   <= f11;
    end
  end

endmodule

// ===== rtl/core/bpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload
module bpc_div #(
  parameter int W  = bpc_pkg::DIV_W,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [W-1:0]  quotient,
  output logic [PW-1:0] out_pay
);

  logic          v   [0:W];
  logic [W-1:0]  rem [0:W];
  logic [W-1:0]  q   [0:W];
  logic [W-1:0]  d   [0:W];
  logic [PW-1:0] pay [0:W];

  assign v[0]   = in_valid;
  assign rem[0] = '0;
  assign q[0]   = dividend;
  assign d[0]   = divisor;
  assign pay[0] = in_pay;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] trial;
    logic [W:0] diff;
    assign trial = {rem[i], q[i][W-1]};
    assign diff  = trial - {1'b0, d[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[W]) begin
          rem[i+1] <= diff[W-1:0];
          q[i+1]   <= {q[i][W-2:0], 1'b1};
        end else begin
          rem[i+1] <= trial[W-1:0];
          q[i+1]   <= {q[i][W-2:0], 1'b0};
        end
        d[i+1]   <= d[i];
        pay[i+1] <= pay[i];
      end
    end
  end

  assign out_valid = v[W];
  assign quotient  = q[W];
  assign out_pay   = pay[W];

endmodule

// ===== rtl/core/bpc_checker.sv =====
// Port-level checker for the pressure compensation block, bound to the top
`include "barometric_pressure_compensation_assert.svh"
module bpc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] temp_tenths,
  input logic signed [31:0] pressure_pa,
  input logic               div_fault
);

  `BPC_ASSERT_NOW(a_fault_zero, clk, rst, out_valid && div_fault, temp_tenths == 32'sd0 && pressure_pa == 32'sd0, "fault result not zero")
  `BPC_ASSERT_NOW(a_stall_only_blocked, clk, rst, !out_stall, !in_stall, "input stalled while output free")
  `BPC_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && out_stall, out_valid && $stable(temp_tenths) && $stable(pressure_pa) && $stable(div_fault), "stalled result changed")
  `BPC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "result right after reset")

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .temp_tenths(temp_tenths),
  .pressure_pa(pressure_pa), .div_fault(div_fault)
);

// ===== verif/testbench.sv =====
// Testbench for the pressure compensation pipeline: table-driven and random requests
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 76;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [31:0] temp;
    logic signed [31:0] pres;
    logic               fault;
  } comp_t;

  typedef struct {
    logic [15:0] ut;
    logic [18:0] up;
    logic        known;  // expected value typed in
    comp_t       res;
  } vec_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_stall = 0, cfg_we = 0;
  logic in_stall, out_valid, div_fault;
  logic [15:0] raw_temp = 0;
  logic [18:0] raw_pressure = 0;
  logic signed [31:0] temp_tenths, pressure_pa;
  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index = bpc_pkg::CFG_AC123;
  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data = 0;

  logic [47:0] ac123, ac456;
  logic [31:0] b12, mcmd;
  logic [1:0]  oss;

  comp_t expected_q[$];
  int    errors = 0;
  int    cycles = 0;
  int    stall_run = 0;

  barometric_pressure_compensation dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] quot(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic comp_t compensate(logic [15:0] ut_in, logic [18:0] up_in);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t, den;
    comp_t r;
    ac1 = sx16(ac123[15:0]); ac2 = sx16(ac123[31:16]); ac3 = sx16(ac123[47:32]);
    ac4 = {16'b0, ac456[15:0]}; ac5 = {16'b0, ac456[31:16]};
    ac6 = {16'b0, ac456[47:32]};
    b1 = sx16(b12[15:0]); b2 = sx16(b12[31:16]);
    mc = sx16(mcmd[15:0]); md = sx16(mcmd[31:16]);
    ut = {16'b0, ut_in}; up = {13'b0, up_in};
    r = '{temp: 0, pres: 0, fault: 1};
    x1 = asr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = quot(mc << 11, den);
    b5 = x1 + x2;
    t = asr(b5 + 8, 4);
    b6 = b5 - bpc_pkg::B6_OFFSET;
    sq = asr(b6 * b6, 12);
    x1 = asr(b2 * sq, 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = quot(((ac1 * 4 + x3) << oss) + 2, 4);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * sq, 16);
    x3 = asr(x1 + x2 + 2, 2);
    b4 = (ac4 * (x3 + bpc_pkg::B4_BIAS)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (bpc_pkg::B7_SCALE >> oss);
    if (!b7[31]) p = (b7 * 2) / b4;
    else p = (b7 / b4) * 2;
    x1 = asr(p, 8) * asr(p, 8);
    x1 = asr(x1 * bpc_pkg::P_C1, 16);
    x2 = asr(bpc_pkg::P_C2 * p, 16);
    p = p + asr(x1 + x2 + bpc_pkg::P_C3, 4);
    r = '{temp: t, pres: p, fault: 0};
    return r;
  endfunction

  // result checker with random back-pressure, a few long stall runs
  always @(posedge clk) begin
    comp_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (temp_tenths !== e.temp) begin
            $error("temp_tenths exp %0d got %0d", e.temp, temp_tenths); errors++;
          end
          if (pressure_pa !== e.pres) begin
            $error("pressure_pa exp %0d got %0d", e.pres, pressure_pa); errors++;
          end
          if (div_fault !== e.fault) begin
            $error("div_fault exp %0b got %0b", e.fault, div_fault); errors++;
          end
        end
      end
      if (stall_run > 0) begin
        out_stall <= 1;
        stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 99) < 2) begin
        out_stall <= 1;
        stall_run <= int'($urandom_range(10, 40));
      end else if ($urandom_range(0, 99) < 70) begin
        out_stall <= 0;
      end else begin
        out_stall <= $urandom_range(0, 3) == 0;
      end
    end
  end

  task automatic gap();
    int n;
    n = $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 9) == 0 ?
        $urandom_range(10, 40) : $urandom_range(1, 3));
    repeat (n) @(posedge clk);
  endtask

  task automatic send(logic [15:0] ut, logic [18:0] up, logic known, comp_t res);
    comp_t e;
    e = compensate(ut, up);
    if (known && e !== res) begin
      $error("typed expectation disagrees with prediction for ut=%0d", ut);
      errors++;
    end
    in_valid <= 1;
    raw_temp <= ut;
    raw_pressure <= up;
    expected_q.push_back(e);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drop_valid();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [bpc_pkg::CFG_IDX_W-1:0] idx, logic [47:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      bpc_pkg::CFG_AC123: ac123 = val;
      bpc_pkg::CFG_AC456: ac456 = val;
      bpc_pkg::CFG_B12:   b12 = val[31:0];
      bpc_pkg::CFG_MCMD:  mcmd = val[31:0];
      bpc_pkg::CFG_OSS:   oss = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // datasheet calibration, all-ones words or random ones
  task automatic set_cal(int mode);
    if (mode == 0) begin
      write_reg(bpc_pkg::CFG_AC123, {16'hC7B8, 16'hFBA5, 16'h1A20} ^ 48'h0);
      write_reg(bpc_pkg::CFG_AC123, {16'(-14383), 16'(-72), 16'(408)});
      write_reg(bpc_pkg::CFG_AC456, {16'd23153, 16'd32757, 16'd32741});
      write_reg(bpc_pkg::CFG_B12, {16'd0, 16'd4, 16'd6190});
      write_reg(bpc_pkg::CFG_MCMD, {16'd0, 16'd2868, 16'(-8711)});
    end else if (mode == 1) begin
      write_reg(bpc_pkg::CFG_AC123, 48'hFFFF_FFFF_FFFF);
      write_reg(bpc_pkg::CFG_AC456, 48'hFFFF_FFFF_FFFF);
      write_reg(bpc_pkg::CFG_B12, 48'hFFFF_FFFF);
      write_reg(bpc_pkg::CFG_MCMD, 48'hFFFF_FFFF);
    end else begin
      write_reg(bpc_pkg::CFG_AC123, 48'({$urandom, $urandom}));
      write_reg(bpc_pkg::CFG_AC456, 48'({$urandom, $urandom}));
      write_reg(bpc_pkg::CFG_B12, 48'($urandom));
      write_reg(bpc_pkg::CFG_MCMD, 48'($urandom));
    end
  endtask

  initial begin
    vec_t table_rows[$];
    comp_t zero_fault;
    int mode;
    zero_fault = '{temp: 0, pres: 0, fault: 1};
    ac123 = 0; ac456 = 0; b12 = 0; mcmd = 0; oss = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset MD=0 and X1=0, so every request divides by zero
    table_rows.push_back('{16'd0, 19'd0, 1'b1, zero_fault});
    table_rows.push_back('{16'hFFFF, 19'h7FFFF, 1'b1, zero_fault});
    foreach (table_rows[i]) begin
      send(table_rows[i].ut, table_rows[i].up, table_rows[i].known, table_rows[i].res);
      drop_valid();
      gap();
    end
    drain();

    // datasheet example and field extremes at each oversampling setting
    set_cal(0);
    for (int o = 0; o < 4; o++) begin
      write_reg(bpc_pkg::CFG_OSS, 48'(o));
      send(16'd27898, 19'd23843, 1'b0, zero_fault);
      send(16'd0, 19'd0, 1'b0, zero_fault);
      send(16'hFFFF, 19'h7FFFF, 1'b0, zero_fault);
      send(16'h5555, 19'h2AAAA, 1'b0, zero_fault);
      send(16'hAAAA, 19'h55555, 1'b0, zero_fault);
      drain();
    end
    // MD = -X1 forces a temperature-side zero divisor
    write_reg(bpc_pkg::CFG_AC456, {16'd0, 16'd0, 16'd0});
    write_reg(bpc_pkg::CFG_MCMD, {16'd0, 16'd0, 16'd5});
    send(16'd1234, 19'd1000, 1'b0, zero_fault);
    drain();
    // AC4 = 0 forces a pressure-side zero divisor
    write_reg(bpc_pkg::CFG_MCMD, {16'd0, 16'd1, 16'd5});
    send(16'd1234, 19'd1000, 1'b0, zero_fault);
    drain();
    // most negative MC over MD = -1
    write_reg(bpc_pkg::CFG_AC456, {16'd0, 16'd0, 16'd1});
    write_reg(bpc_pkg::CFG_MCMD, {16'd0, 16'hFFFF, 16'h8000});
    send(16'd0, 19'd0, 1'b0, zero_fault);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      mode = phase == 9 ? 1 : (phase % 3 == 0 ? 0 : 2);
      set_cal(mode);
      write_reg(bpc_pkg::CFG_OSS, 48'(phase % 4));
      for (int k = 0; k < 125; k++) begin
        if ($urandom_range(0, 3) == 0)
          send(16'($urandom), 19'($urandom), 1'b0, zero_fault);
        else
          send(16'($urandom_range(20000, 36000)), 19'($urandom_range(15000, 120000)),
               1'b0, zero_fault);
        if ($urandom_range(0, 2) == 0) begin
          drop_valid();
          gap();
        end
      end
      drain();
    end

    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bpc_pkg.sv
rtl/core/bpc_div.sv
rtl/core/barometric_pressure_compensation.sv
rtl/core/bpc_checker.sv
verif/testbench.sv
